### rtl/gcb_pkg.sv
// Shared types for the generator coordinate bound block.
// Holds the row classification codes, the bound kind codes and the control structs.
// Used by the front, back and result modules and the top level; depends on nothing else.
package gcb_pkg;

  // Classification of one generator row, decided at the front.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_LINE    = 3'd1,
    OP_RAY_POS = 3'd2,
    OP_RAY_NEG = 3'd3,
    OP_VERTEX  = 3'd4
  } op_e;

  // Kind of one side of the interval.
  typedef enum logic [1:0] {
    KIND_FINITE = 2'd0,
    KIND_INF    = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  // Control part of a classified row.
  typedef struct packed {
    op_e  op;
    logic last;
  } row_ctl_t;

  // Kinds of both sides of a finished interval.
  typedef struct packed {
    kind_e low_kind;
    kind_e high_kind;
  } kinds_t;

endpackage

### rtl/gcb_front.sv
// Front of the generator coordinate bound block: classifies each incoming row.
// Narrows the coefficients to the working width and decides the row's effect.
// Depends on gcb_pkg.
module gcb_front #(
  parameter int CoefWidth = 32
) (
  input  logic                        strict_mode_i,
  input  logic                        row_is_line_i,
  input  logic                        eps_nonzero_i,
  input  logic [30:0]                 denom_i,
  input  logic [31:0]                 coord_i,
  input  logic                        last_row_i,
  output gcb_pkg::row_ctl_t           ctl_o,
  output logic signed [CoefWidth-1:0] coord_o,
  output logic [CoefWidth-2:0]        den_o
);
  import gcb_pkg::*;

  logic signed [CoefWidth-1:0] coord_w;
  logic [CoefWidth-2:0]        den_w;

  // Only the low bits of each coefficient take part.
  assign coord_w = $signed(coord_i[CoefWidth-1:0]);
  assign den_w   = denom_i[CoefWidth-2:0];

  // Decide what the row does to the running interval.
  always_comb begin
    ctl_o.last = last_row_i;
    ctl_o.op   = OP_NONE;
    if (!(strict_mode_i && eps_nonzero_i)) begin
      if (row_is_line_i) begin
        if (coord_w != '0) ctl_o.op = OP_LINE;
      end else if (den_w == '0) begin
        if (coord_w > 0) begin
          ctl_o.op = OP_RAY_POS;
        end else if (coord_w < 0) begin
          ctl_o.op = OP_RAY_NEG;
        end
      end else begin
        ctl_o.op = OP_VERTEX;
      end
    end
  end

  assign coord_o = coord_w;
  assign den_o   = den_w;

endmodule

### rtl/gcb_fifo.sv
// Two-entry register queue between the front and the back of the block.
// Generic in its data width; push and pop may happen in the same cycle.
// Depends on nothing else.
module gcb_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### rtl/gcb_back.sv
// Back of the generator coordinate bound block: keeps the running interval.
// Applies one classified row per cycle while rows are queued and the result stage
// can take a final one; hands the interval on at the last row. Depends on gcb_pkg.
module gcb_back #(
  parameter int CoefWidth = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  gcb_pkg::row_ctl_t           q_ctl_i,
  input  logic signed [CoefWidth-1:0] q_coord_i,
  input  logic [CoefWidth-2:0]        q_den_i,
  output logic                        q_pop_o,
  input  logic                        res_ready_i,
  output logic                        res_valid_o,
  output gcb_pkg::kinds_t             res_kinds_o,
  output logic signed [CoefWidth-1:0] res_low_num_o,
  output logic [CoefWidth-2:0]        res_low_den_o,
  output logic signed [CoefWidth-1:0] res_high_num_o,
  output logic [CoefWidth-2:0]        res_high_den_o
);
  import gcb_pkg::*;

  kind_e                       low_kind_q, low_kind_d;
  kind_e                       high_kind_q, high_kind_d;
  logic signed [CoefWidth-1:0] low_num_q, low_num_d;
  logic signed [CoefWidth-1:0] high_num_q, high_num_d;
  logic [CoefWidth-2:0]        low_den_q, low_den_d;
  logic [CoefWidth-2:0]        high_den_q, high_den_d;

  logic signed [2*CoefWidth-1:0] hi_lhs, hi_rhs, lo_lhs, lo_rhs;

  // Cross-multiplied comparison of the row's value with the stored bounds.
  assign hi_lhs = q_coord_i * $signed({1'b0, high_den_q});
  assign hi_rhs = high_num_q * $signed({1'b0, q_den_i});
  assign lo_lhs = q_coord_i * $signed({1'b0, low_den_q});
  assign lo_rhs = low_num_q * $signed({1'b0, q_den_i});

  // A final row waits until the result stage can take the interval.
  assign q_pop_o = !q_empty_i && (!q_ctl_i.last || res_ready_i);

  // Next interval after applying the row at the head of the queue.
  always_comb begin
    low_kind_d  = low_kind_q;
    low_num_d   = low_num_q;
    low_den_d   = low_den_q;
    high_kind_d = high_kind_q;
    high_num_d  = high_num_q;
    high_den_d  = high_den_q;
    unique case (q_ctl_i.op)
      OP_LINE: begin
        low_kind_d  = KIND_INF;
        low_num_d   = '0;
        low_den_d   = '0;
        high_kind_d = KIND_INF;
        high_num_d  = '0;
        high_den_d  = '0;
      end
      OP_RAY_POS: begin
        high_kind_d = KIND_INF;
        high_num_d  = '0;
        high_den_d  = '0;
      end
      OP_RAY_NEG: begin
        low_kind_d = KIND_INF;
        low_num_d  = '0;
        low_den_d  = '0;
      end
      OP_VERTEX: begin
        if (high_kind_q == KIND_EMPTY ||
            (high_kind_q == KIND_FINITE && hi_lhs > hi_rhs)) begin
          high_kind_d = KIND_FINITE;
          high_num_d  = q_coord_i;
          high_den_d  = q_den_i;
        end
        if (low_kind_q == KIND_EMPTY ||
            (low_kind_q == KIND_FINITE && lo_lhs < lo_rhs)) begin
          low_kind_d = KIND_FINITE;
          low_num_d  = q_coord_i;
          low_den_d  = q_den_i;
        end
      end
      default: ;
    endcase
  end

  // The finished interval goes out as the row is applied.
  assign res_valid_o           = q_pop_o && q_ctl_i.last;
  assign res_kinds_o.low_kind  = low_kind_d;
  assign res_kinds_o.high_kind = high_kind_d;
  assign res_low_num_o         = low_num_d;
  assign res_low_den_o         = low_den_d;
  assign res_high_num_o        = high_num_d;
  assign res_high_den_o        = high_den_d;

  // Running interval, cleared after each final row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_kind_q  <= KIND_EMPTY;
      low_num_q   <= '0;
      low_den_q   <= '0;
      high_kind_q <= KIND_EMPTY;
      high_num_q  <= '0;
      high_den_q  <= '0;
    end else if (q_pop_o) begin
      if (q_ctl_i.last) begin
        low_kind_q  <= KIND_EMPTY;
        low_num_q   <= '0;
        low_den_q   <= '0;
        high_kind_q <= KIND_EMPTY;
        high_num_q  <= '0;
        high_den_q  <= '0;
      end else begin
        low_kind_q  <= low_kind_d;
        low_num_q   <= low_num_d;
        low_den_q   <= low_den_d;
        high_kind_q <= high_kind_d;
        high_num_q  <= high_num_d;
        high_den_q  <= high_den_d;
      end
    end
  end

endmodule

### rtl/gcb_result.sv
// Result stages of the generator coordinate bound block.
// Forms the cross products for the point test, then holds the request for the output.
// Depends on gcb_pkg.
module gcb_result #(
  parameter int CoefWidth = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  gcb_pkg::kinds_t             in_kinds_i,
  input  logic signed [CoefWidth-1:0] in_low_num_i,
  input  logic [CoefWidth-2:0]        in_low_den_i,
  input  logic signed [CoefWidth-1:0] in_high_num_i,
  input  logic [CoefWidth-2:0]        in_high_den_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  lower_kind_o,
  output logic [31:0]                 lower_num_o,
  output logic [30:0]                 lower_den_o,
  output logic [1:0]                  upper_kind_o,
  output logic [31:0]                 upper_num_o,
  output logic [30:0]                 upper_den_o,
  output logic                        is_point_o
);
  import gcb_pkg::*;

  logic                          s1_valid_q, s2_valid_q;
  logic                          s1_free, s2_free;
  kinds_t                        s1_kinds_q, s2_kinds_q;
  logic signed [CoefWidth-1:0]   s1_low_num_q, s1_high_num_q;
  logic signed [CoefWidth-1:0]   s2_low_num_q, s2_high_num_q;
  logic [CoefWidth-2:0]          s1_low_den_q, s1_high_den_q;
  logic [CoefWidth-2:0]          s2_low_den_q, s2_high_den_q;
  logic signed [2*CoefWidth-1:0] low_prod, high_prod;
  logic signed [2*CoefWidth-1:0] s2_low_prod_q, s2_high_prod_q;

  assign s2_free    = !s2_valid_q || out_ready_i;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;

  // Cross products of the two bounds, registered before the compare.
  assign low_prod  = s1_low_num_q * $signed({1'b0, s1_high_den_q});
  assign high_prod = s1_high_num_q * $signed({1'b0, s1_low_den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) s1_valid_q <= in_valid_i;
      if (s2_free) s2_valid_q <= s1_valid_q;
    end
  end

  // Payload stages need no reset.
  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_kinds_q    <= in_kinds_i;
      s1_low_num_q  <= in_low_num_i;
      s1_low_den_q  <= in_low_den_i;
      s1_high_num_q <= in_high_num_i;
      s1_high_den_q <= in_high_den_i;
    end
    if (s2_free && s1_valid_q) begin
      s2_kinds_q     <= s1_kinds_q;
      s2_low_num_q   <= s1_low_num_q;
      s2_low_den_q   <= s1_low_den_q;
      s2_high_num_q  <= s1_high_num_q;
      s2_high_den_q  <= s1_high_den_q;
      s2_low_prod_q  <= low_prod;
      s2_high_prod_q <= high_prod;
    end
  end

  // Output request, widened to the port widths.
  assign out_valid_o  = s2_valid_q;
  assign lower_kind_o = s2_kinds_q.low_kind;
  assign upper_kind_o = s2_kinds_q.high_kind;
  assign lower_num_o  = 32'(s2_low_num_q);
  assign upper_num_o  = 32'(s2_high_num_q);
  assign lower_den_o  = 31'(s2_low_den_q);
  assign upper_den_o  = 31'(s2_high_den_q);
  assign is_point_o   = (s2_kinds_q.low_kind == KIND_FINITE) &&
                        (s2_kinds_q.high_kind == KIND_FINITE) &&
                        (s2_low_prod_q == s2_high_prod_q);

endmodule

### rtl/generator_coordinate_bound.sv
// Generator coordinate bound: interval of one coordinate over streamed generator rows.
// Throughput: one row per cycle while the queue between front and back is not full.
// The interval passes from the queue through result stages s1 and s2 to the output.
// Reset: asynchronous, active low; the interval returns to empty on both sides and
// strict mode is off. Depends on gcb_pkg, gcb_front, gcb_fifo, gcb_back, gcb_result.
module generator_coordinate_bound #(
  parameter int COEF_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_strict_mode_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        row_is_line_i,
  input  logic        eps_nonzero_i,
  input  logic [30:0] denom_i,
  input  logic [31:0] coord_i,
  input  logic        last_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  lower_kind_o,
  output logic [31:0] lower_num_o,
  output logic [30:0] lower_den_o,
  output logic [1:0]  upper_kind_o,
  output logic [31:0] upper_num_o,
  output logic [30:0] upper_den_o,
  output logic        is_point_o
);
  import gcb_pkg::*;

  localparam int CtlBits  = $bits(row_ctl_t);
  localparam int ItemBits = CtlBits + COEF_WIDTH + COEF_WIDTH - 1;

  logic                         strict_mode_q;
  row_ctl_t                     fr_ctl, q_ctl;
  logic signed [COEF_WIDTH-1:0] fr_coord, q_coord;
  logic [COEF_WIDTH-2:0]        fr_den, q_den;
  logic [ItemBits-1:0]          push_data, pop_data;
  logic                         q_full, q_empty, q_pop, push;
  logic                         res_valid, res_ready;
  kinds_t                       res_kinds;
  logic signed [COEF_WIDTH-1:0] res_low_num, res_high_num;
  logic [COEF_WIDTH-2:0]        res_low_den, res_high_den;

  // Configuration register, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      strict_mode_q <= cfg_strict_mode_i;
    end
  end

  // Classify the incoming row.
  gcb_front #(.CoefWidth(COEF_WIDTH)) u_front (
    .strict_mode_i (strict_mode_q),
    .row_is_line_i (row_is_line_i),
    .eps_nonzero_i (eps_nonzero_i),
    .denom_i       (denom_i),
    .coord_i       (coord_i),
    .last_row_i    (last_row_i),
    .ctl_o         (fr_ctl),
    .coord_o       (fr_coord),
    .den_o         (fr_den)
  );

  // Queue between front and back.
  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;
  assign push_data  = {fr_ctl, fr_coord, fr_den};

  gcb_fifo #(.Width(ItemBits)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  assign q_ctl   = row_ctl_t'(pop_data[ItemBits-1 -: CtlBits]);
  assign q_coord = $signed(pop_data[COEF_WIDTH-1 + COEF_WIDTH-1 -: COEF_WIDTH]);
  assign q_den   = pop_data[COEF_WIDTH-2:0];

  // Running interval.
  gcb_back #(.CoefWidth(COEF_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_ctl_i        (q_ctl),
    .q_coord_i      (q_coord),
    .q_den_i        (q_den),
    .q_pop_o        (q_pop),
    .res_ready_i    (res_ready),
    .res_valid_o    (res_valid),
    .res_kinds_o    (res_kinds),
    .res_low_num_o  (res_low_num),
    .res_low_den_o  (res_low_den),
    .res_high_num_o (res_high_num),
    .res_high_den_o (res_high_den)
  );

  // Point test and output request.
  gcb_result #(.CoefWidth(COEF_WIDTH)) u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (res_valid),
    .in_ready_o    (res_ready),
    .in_kinds_i    (res_kinds),
    .in_low_num_i  (res_low_num),
    .in_low_den_i  (res_low_den),
    .in_high_num_i (res_high_num),
    .in_high_den_i (res_high_den),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lower_kind_o  (lower_kind_o),
    .lower_num_o   (lower_num_o),
    .lower_den_o   (lower_den_o),
    .upper_kind_o  (upper_kind_o),
    .upper_num_o   (upper_num_o),
    .upper_den_o   (upper_den_o),
    .is_point_o    (is_point_o)
  );

endmodule

### tb/tb_generator_coordinate_bound.sv
`timescale 1ns / 100ps
// Self-checking testbench for generator_coordinate_bound: a directed table, then random rows.
// It predicts each untyped interval itself, takes the hand-written one for typed directed rows,
// and compares each one field by field. Depends on gcb_pkg and the generator_coordinate_bound RTL only.
module tb_generator_coordinate_bound;
  import gcb_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int IDLE_PCT       = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 6;
  localparam int PHASE_ROWS     = 305;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_ROWS       = 24;

  // One generator row as it is driven onto the input request.
  typedef struct packed {
    logic        is_line;
    logic        eps;
    logic [30:0] denom;
    logic [31:0] coord;
    logic        last;
  } row_t;

  // One finished interval as it leaves the block.
  typedef struct packed {
    kind_e       lo_kind;
    logic [31:0] lo_num;
    logic [30:0] lo_den;
    kind_e       hi_kind;
    logic [31:0] hi_num;
    logic [30:0] hi_den;
    logic        point;
  } bound_t;

  // A line of the directed table: strict mode, the row, and an optional hand-written interval.
  typedef struct packed {
    logic   strict;
    row_t   row;
    logic   typed;
    bound_t want;
  } dir_t;

  localparam bound_t UNTYPED    = '0;
  localparam bound_t EMPTY_BOTH = '{KIND_EMPTY, 32'd0, 31'd0, KIND_EMPTY, 32'd0, 31'd0, 1'b0};
  localparam bound_t INF_BOTH   = '{KIND_INF, 32'd0, 31'd0, KIND_INF, 32'd0, 31'd0, 1'b0};

  // Directed rows: zero-coordinate lines and rays, opposing rays, the coordinate and
  // constant extremes, equal vertex values, sticky infinite sides and skipped rows.
  localparam dir_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{1'b0, '{1'b1, 1'b0, 31'd0, 32'd0, 1'b1}, 1'b1, EMPTY_BOTH},
    '{1'b0, '{1'b0, 1'b0, 31'd0, 32'd0, 1'b1}, 1'b1, EMPTY_BOTH},
    '{1'b0, '{1'b0, 1'b0, 31'd0, 32'd1, 1'b0}, 1'b0, UNTYPED},
    '{1'b0, '{1'b0, 1'b0, 31'd0, 32'hffffffff, 1'b1}, 1'b1, INF_BOTH},
    '{1'b0, '{1'b0, 1'b0, 31'd1, 32'h7fffffff, 1'b1}, 1'b1,
      '{KIND_FINITE, 32'h7fffffff, 31'd1, KIND_FINITE, 32'h7fffffff, 31'd1, 1'b1}},
    '{1'b0, '{1'b0, 1'b0, 31'h7fffffff, 32'h80000000, 1'b0}, 1'b0, UNTYPED},
    '{1'b0, '{1'b0, 1'b0, 31'd1, 32'h7fffffff, 1'b1}, 1'b1,
      '{KIND_FINITE, 32'h80000000, 31'h7fffffff, KIND_FINITE, 32'h7fffffff, 31'd1, 1'b0}},
    '{1'b0, '{1'b0, 1'b0, 31'd4, 32'd2, 1'b0}, 1'b0, UNTYPED},
    '{1'b0, '{1'b0, 1'b0, 31'd2, 32'd1, 1'b1}, 1'b1,
      '{KIND_FINITE, 32'd2, 31'd4, KIND_FINITE, 32'd2, 31'd4, 1'b1}},
    '{1'b0, '{1'b0, 1'b0, 31'd1, 32'd3, 1'b0}, 1'b0, UNTYPED},
    '{1'b0, '{1'b0, 1'b0, 31'd0, 32'd5, 1'b0}, 1'b0, UNTYPED},
    '{1'b0, '{1'b0, 1'b0, 31'd1, 32'd7, 1'b1}, 1'b1,
      '{KIND_FINITE, 32'd3, 31'd1, KIND_INF, 32'd0, 31'd0, 1'b0}},
    '{1'b0, '{1'b1, 1'b0, 31'd9, 32'd1, 1'b0}, 1'b0, UNTYPED},
    '{1'b0, '{1'b0, 1'b0, 31'd2, 32'd4, 1'b1}, 1'b1, INF_BOTH},
    '{1'b0, '{1'b0, 1'b1, 31'h7fffffff, 32'hffffffff, 1'b1}, 1'b1,
      '{KIND_FINITE, 32'hffffffff, 31'h7fffffff, KIND_FINITE, 32'hffffffff, 31'h7fffffff, 1'b1}},
    '{1'b1, '{1'b0, 1'b1, 31'd1, 32'd9, 1'b0}, 1'b0, UNTYPED},
    '{1'b1, '{1'b0, 1'b0, 31'd3, 32'd2, 1'b1}, 1'b1,
      '{KIND_FINITE, 32'd2, 31'd3, KIND_FINITE, 32'd2, 31'd3, 1'b1}},
    '{1'b1, '{1'b1, 1'b1, 31'd0, 32'd5, 1'b0}, 1'b0, UNTYPED},
    '{1'b1, '{1'b0, 1'b1, 31'd0, 32'hfffffffd, 1'b0}, 1'b0, UNTYPED},
    '{1'b1, '{1'b0, 1'b1, 31'd1, 32'd4, 1'b1}, 1'b1, EMPTY_BOTH},
    '{1'b1, '{1'b0, 1'b0, 31'd3, 32'd1, 1'b0}, 1'b0, UNTYPED},
    '{1'b1, '{1'b0, 1'b0, 31'd3, 32'hffffffff, 1'b0}, 1'b0, UNTYPED},
    '{1'b1, '{1'b1, 1'b1, 31'd0, 32'd7, 1'b1}, 1'b1,
      '{KIND_FINITE, 32'hffffffff, 31'd3, KIND_FINITE, 32'd1, 31'd3, 1'b0}},
    '{1'b1, '{1'b0, 1'b0, 31'd5, 32'd0, 1'b1}, 1'b1,
      '{KIND_FINITE, 32'd0, 31'd5, KIND_FINITE, 32'd0, 31'd5, 1'b1}}
  };

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_strict = 1'b0;
  logic        cfg_ready;
  logic        in_valid  = 1'b0;
  row_t        in_row    = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  lower_kind;
  logic [31:0] lower_num;
  logic [30:0] lower_den;
  logic [1:0]  upper_kind;
  logic [31:0] upper_num;
  logic [30:0] upper_den;
  logic        is_point;

  // Idling control shared by both sides; the hold-off request is served once by the receiver.
  logic calm         = 1'b0;
  logic hold_request = 1'b0;
  logic hold_taken   = 1'b0;

  // Running interval of the predictor and its copy of the strict-mode register.
  logic               strict_shadow = 1'b0;
  kind_e              acc_lo_kind   = KIND_EMPTY;
  logic signed [31:0] acc_lo_num    = '0;
  logic        [30:0] acc_lo_den    = '0;
  kind_e              acc_hi_kind   = KIND_EMPTY;
  logic signed [31:0] acc_hi_num    = '0;
  logic        [30:0] acc_hi_den    = '0;

  bound_t intervals_due [$];

  int rows_sent         = 0;
  int rows_skipped      = 0;
  int intervals_checked = 0;
  int point_intervals   = 0;
  int strict_writes     = 0;
  int mismatches        = 0;
  int quiet_cycles      = 0;

  generator_coordinate_bound i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_strict_mode_i (cfg_strict),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .row_is_line_i     (in_row.is_line),
    .eps_nonzero_i     (in_row.eps),
    .denom_i           (in_row.denom),
    .coord_i           (in_row.coord),
    .last_row_i        (in_row.last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .lower_kind_o      (lower_kind),
    .lower_num_o       (lower_num),
    .lower_den_o       (lower_den),
    .upper_kind_o      (upper_kind),
    .upper_num_o       (upper_num),
    .upper_den_o       (upper_den),
    .is_point_o        (is_point)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one row to the running interval; returns 1 with the finished interval on a last row.
  function automatic logic step_interval(input row_t r, output bound_t res);
    longint cv;
    longint dv;
    res = '0;
    cv  = longint'($signed(r.coord));
    dv  = longint'(r.denom);
    if (strict_shadow && r.eps) begin
      rows_skipped++;
    end else if (r.is_line) begin
      if (cv != 0) begin
        acc_lo_kind = KIND_INF;
        acc_lo_num  = '0;
        acc_lo_den  = '0;
        acc_hi_kind = KIND_INF;
        acc_hi_num  = '0;
        acc_hi_den  = '0;
      end
    end else if (dv == 0) begin
      if (cv > 0) begin
        acc_hi_kind = KIND_INF;
        acc_hi_num  = '0;
        acc_hi_den  = '0;
      end else if (cv < 0) begin
        acc_lo_kind = KIND_INF;
        acc_lo_num  = '0;
        acc_lo_den  = '0;
      end
    end else begin
      // Exact comparison of coord/denom against the stored fractions by cross-multiplying.
      if (acc_hi_kind == KIND_EMPTY || (acc_hi_kind == KIND_FINITE &&
          cv * longint'(acc_hi_den) > longint'(acc_hi_num) * dv)) begin
        acc_hi_kind = KIND_FINITE;
        acc_hi_num  = r.coord;
        acc_hi_den  = r.denom;
      end
      if (acc_lo_kind == KIND_EMPTY || (acc_lo_kind == KIND_FINITE &&
          cv * longint'(acc_lo_den) < longint'(acc_lo_num) * dv)) begin
        acc_lo_kind = KIND_FINITE;
        acc_lo_num  = r.coord;
        acc_lo_den  = r.denom;
      end
    end
    if (!r.last) return 1'b0;

    res.lo_kind = acc_lo_kind;
    res.lo_num  = acc_lo_num;
    res.lo_den  = acc_lo_den;
    res.hi_kind = acc_hi_kind;
    res.hi_num  = acc_hi_num;
    res.hi_den  = acc_hi_den;
    res.point   = acc_lo_kind == KIND_FINITE && acc_hi_kind == KIND_FINITE &&
                  longint'(acc_lo_num) * longint'(acc_hi_den) ==
                  longint'(acc_hi_num) * longint'(acc_lo_den);
    if (res.point) point_intervals++;
    // The interval starts afresh after it has been emitted.
    acc_lo_kind = KIND_EMPTY;
    acc_lo_num  = '0;
    acc_lo_den  = '0;
    acc_hi_kind = KIND_EMPTY;
    acc_hi_num  = '0;
    acc_hi_den  = '0;
    return 1'b1;
  endfunction

  // Coordinates lean towards small values and the extremes so that ties and overflow corners occur.
  function automatic logic [31:0] random_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return 32'($urandom_range(8)) - 32'd4;
    if (pick < 42) begin
      case ($urandom_range(3))
        0:       return 32'h7fffffff;
        1:       return 32'h80000000;
        2:       return 32'hffffffff;
        default: return 32'd0;
      endcase
    end
    return 32'($urandom);
  endfunction

  // A nonzero homogenising constant for a vertex.
  function automatic logic [30:0] random_denom();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 31'($urandom_range(1, 4));
    if (pick < 50) return 31'h7fffffff;
    return 31'($urandom_range(1, 32'h7fffffff));
  endfunction

  // Mostly vertices, with some rays and a few lines; a quarter of the rows carry epsilon.
  function automatic row_t random_row(input logic last);
    row_t r;
    int   pick;
    r       = '0;
    r.last  = last;
    r.eps   = ($urandom_range(3) == 0);
    r.coord = random_coord();
    pick    = $urandom_range(99);
    if (pick < 6) begin
      r.is_line = 1'b1;
      r.denom   = 31'($urandom);
    end else if (pick < 20) begin
      r.denom = '0;
    end else begin
      r.denom = random_denom();
    end
    return r;
  endfunction

  // Offers one row, waits for the request to be taken and records any interval it closes.
  task automatic send_row(input row_t r, input logic typed, input bound_t want);
    bound_t predicted;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row   <= r;
    do @(posedge clk); while (!in_ready);
    rows_sent++;
    if (step_interval(r, predicted)) intervals_due.push_back(typed ? want : predicted);
  endtask

  // Stops offering rows and waits until every interval has come out and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (intervals_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_strict(input logic mode);
    cfg_valid  <= 1'b1;
    cfg_strict <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    strict_shadow  = mode;
    strict_writes++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("interval %0d: %s expected %h, got %h", intervals_checked, name, want, got);
    end
  endtask

  // Receiver: random stalls, a calm stretch, and one long hold-off when asked for.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Each interval taken from the block is checked against the oldest prediction.
  always @(posedge clk) begin : interval_check
    bound_t want;
    if (rst_n && out_valid && out_ready) begin
      if (intervals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("interval emitted with none predicted: lower %0d %h/%h, upper %0d %h/%h",
                   lower_kind, lower_num, lower_den, upper_kind, upper_num, upper_den);
      end else begin
        want = intervals_due.pop_front();
        compare_field("lower_kind", 32'(want.lo_kind), 32'(lower_kind));
        compare_field("lower_num", want.lo_num, lower_num);
        compare_field("lower_den", 32'(want.lo_den), 32'(lower_den));
        compare_field("upper_kind", 32'(want.hi_kind), 32'(upper_kind));
        compare_field("upper_num", want.hi_num, upper_num);
        compare_field("upper_den", 32'(want.hi_den), 32'(upper_den));
        compare_field("is_point", 32'(want.point), 32'(is_point));
        intervals_checked++;
      end
    end
  end

  // Watchdog: too long without any request being taken ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no request taken for %0d cycles", WATCHDOG_LIMIT);
        $display("generator_coordinate_bound regression: fail");
        $finish;
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases alternating strict mode.
  initial begin : stimulus
    int   rows_left;
    int   seq_len;
    int   pick;
    logic mode;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 0 || DIRECTED_ROWS[i].strict != strict_shadow) begin
        settle();
        write_strict(DIRECTED_ROWS[i].strict);
      end
      send_row(DIRECTED_ROWS[i].row, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // The phase with index 2 runs without idling; index 3 carries the receiver hold-off.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      mode = ph[0];
      write_strict(mode);
      calm         <= (ph == 2);
      hold_request <= (ph == 3);
      rows_left = PHASE_ROWS;
      while (rows_left > 0) begin
        pick = $urandom_range(99);
        if (pick < 50)      seq_len = $urandom_range(1, 3);
        else if (pick < 90) seq_len = $urandom_range(4, 8);
        else                seq_len = $urandom_range(9, 20);
        if (seq_len > rows_left) seq_len = rows_left;
        for (int k = 0; k < seq_len; k++) begin
          send_row(random_row(k == seq_len - 1), 1'b0, UNTYPED);
        end
        rows_left -= seq_len;
      end
    end
    settle();

    if (intervals_due.size() != 0)
      $display("%0d predicted intervals never emitted", intervals_due.size());
    $display("Drove %0d generator rows (%0d skipped under strict mode) and checked %0d intervals,",
             rows_sent, rows_skipped, intervals_checked);
    $display("%0d of them single points, over %0d strict-mode writes; %0d field mismatches.",
             point_intervals, strict_writes, mismatches);
    if (mismatches == 0 && intervals_due.size() == 0) begin
      $display("generator_coordinate_bound regression: pass");
    end else begin
      $display("generator_coordinate_bound regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gcb_pkg.sv
rtl/gcb_front.sv
rtl/gcb_fifo.sv
rtl/gcb_back.sv
rtl/gcb_result.sv
rtl/generator_coordinate_bound.sv
tb/tb_generator_coordinate_bound.sv
